FILE: rtl/spi_light_command_slave_defines.svh
// ----------------------------------------------------------------------------
// SPI light command slave: assertion macros
// Shared concurrent assertion forms used by the RTL of the block.
// ----------------------------------------------------------------------------
`ifndef SPI_LIGHT_COMMAND_SLAVE_DEFINES_SVH
`define SPI_LIGHT_COMMAND_SLAVE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SLCS_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SLCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/slcs_pkg.sv
// ----------------------------------------------------------------------------
// SPI light command slave: package
// Item types, frame layout constants and command codes.
// ----------------------------------------------------------------------------
package slcs_pkg;

    localparam int FRAME_BYTES = 6;
    localparam int POS_W       = 3;
    // The last byte of a frame is never read back, so it is not stored.
    localparam int STORE_DEPTH = FRAME_BYTES - 1;

    localparam logic [7:0] END_MARK   = 8'hFF;
    localparam logic [7:0] ERROR_MARK = 8'hEE;

    localparam logic CMD_SPI    = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [7:0] OP_STATUS      = 8'd0;
    localparam logic [7:0] OP_TURN_ON     = 8'd1;
    localparam logic [7:0] OP_TURN_OFF    = 8'd2;
    localparam logic [7:0] OP_ALL         = 8'd3;
    localparam logic [7:0] OP_NONE        = 8'd4;
    localparam logic [7:0] OP_BUTTONS_OFF = 8'd5;
    localparam logic [7:0] OP_BUTTONS_ON  = 8'd6;

    typedef struct packed {
        logic       command;
        logic [7:0] spi_byte;
        logic [7:0] button_pins;
        logic [7:0] sensor_pins;
    } t_in_item;

    typedef struct packed {
        logic [7:0] reply_byte;
        logic [7:0] lights;
        logic       frame_done;
        logic       frame_valid;
    } t_out_item;

endpackage

FILE: rtl/slcs_if.sv
// ----------------------------------------------------------------------------
// SPI light command slave: stream interfaces
// Valid/ready channels for input items and result items.
// ----------------------------------------------------------------------------
interface slcs_in_if;
    import slcs_pkg::*;

    logic     valid;
    logic     ready;
    t_in_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface slcs_out_if;
    import slcs_pkg::*;

    logic      valid;
    logic      ready;
    t_out_item payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/spi_light_command_slave.sv
// ----------------------------------------------------------------------------
// SPI light command slave
// Light controller driven by sample items and by bytes exchanged over SPI.
// ----------------------------------------------------------------------------
// Usage: items arrive on i_item and every item gives exactly one result on
// o_result. A sample item (command set) latches the active-low buttons (unless
// locked) and the sensors and refreshes the lights. An SPI item (command clear)
// carries the byte received from the master; the result carries the byte to
// shift back, and reports whether the byte closed a command frame and whether
// that frame was well formed.
// Pipeline: an accepted item is held in the input register and is processed
// once the result register can move on; its result is then presented from the
// result register. Throughput is one item per cycle while the receiver takes
// results, set by the single pass of logic between the input register and
// the result register.
// Reset (synchronous, active low) empties both registers and clears the
// light, button, sensor, override and error state and the byte position.
// When the receiver stalls, the result register holds its transfer and the
// input register still takes one more item; after that i_item.ready falls
// until the result is taken. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
`include "spi_light_command_slave_defines.svh"

module spi_light_command_slave (
    input  logic              i_clk,
    input  logic              i_rst_n,
    slcs_in_if.sink           i_item,
    slcs_out_if.source        o_result
);
    import slcs_pkg::*;

    // Reply byte slots in the order they are shifted back to the master.
    localparam logic [POS_W-1:0] POS_ERROR   = POS_W'(0);
    localparam logic [POS_W-1:0] POS_SENSORS = POS_W'(1);
    localparam logic [POS_W-1:0] POS_LIGHTS  = POS_W'(2);
    localparam logic [POS_W-1:0] POS_BUTTONS = POS_W'(3);
    localparam logic [POS_W-1:0] POS_ZERO    = POS_W'(4);
    localparam logic [POS_W-1:0] POS_END     = POS_W'(5);

    // Frame slots read back when a frame completes.
    localparam int SLOT_OPCODE    = 0;
    localparam int SLOT_PARAM     = 1;
    localparam int SLOT_PAD_FIRST = 2;
    localparam int SLOT_PAD_LAST  = 4;

    // Handshake and pipeline registers.
    logic      r_in_valid;
    t_in_item  r_in;
    logic      r_out_valid;
    t_out_item r_out;
    logic      advance;
    logic      step;

    // Block state.
    logic [7:0]       r_store [STORE_DEPTH];
    logic [POS_W-1:0] r_pos,        n_pos;
    logic [7:0]       r_override,   n_override;
    logic [7:0]       r_buttons,    n_buttons;
    logic             r_btn_off,    n_btn_off;
    logic [7:0]       r_sensors,    n_sensors;
    logic [7:0]       r_light,      n_light;
    // The error reply bytes are only ever zero or the error mark, so a flag
    // stands for each. The first is sticky; the second is cleared by a sample.
    logic             r_err_sticky, n_err_sticky;
    logic             r_err_recent, n_err_recent;

    t_out_item  res;
    logic [7:0] btn_sample;
    logic [7:0] opcode;
    logic [7:0] param;
    logic       pads_zero;
    logic       spi_in_frame;
    logic       store_wr;

    // The result register moves on when it is empty or being taken; the
    // input register refills whenever its item moves on.
    assign advance        = !r_out_valid || o_result.ready;
    assign step           = r_in_valid && advance;
    assign i_item.ready   = !r_in_valid || advance;
    assign o_result.valid = r_out_valid;
    assign o_result.payload = r_out;

    assign opcode       = r_store[SLOT_OPCODE];
    assign param        = r_store[SLOT_PARAM];
    assign spi_in_frame = (r_in.command == CMD_SPI) && (r_pos < POS_W'(FRAME_BYTES));
    assign store_wr     = step && spi_in_frame && (r_pos < POS_W'(STORE_DEPTH));

    always_comb begin
        pads_zero = 1'b1;
        for (int k = SLOT_PAD_FIRST; k <= SLOT_PAD_LAST; k++) begin
            pads_zero = pads_zero && (r_store[k] == 8'h00);
        end
    end

    assign btn_sample = r_btn_off ? r_buttons : ~r_in.button_pins;

    always_comb begin
        n_pos        = r_pos;
        n_override   = r_override;
        n_buttons    = r_buttons;
        n_btn_off    = r_btn_off;
        n_sensors    = r_sensors;
        n_light      = r_light;
        n_err_sticky = r_err_sticky;
        n_err_recent = r_err_recent;
        res          = '0;

        if (r_in.command == CMD_SAMPLE) begin
            n_buttons    = btn_sample;
            n_light      = btn_sample ^ r_override;
            n_sensors    = r_in.sensor_pins;
            n_err_recent = 1'b0;
        end else if (spi_in_frame) begin
            unique case (r_pos)
                POS_ERROR:   res.reply_byte = r_err_sticky ? ERROR_MARK : 8'h00;
                POS_SENSORS: res.reply_byte = r_err_recent ? ERROR_MARK : r_sensors;
                POS_LIGHTS:  res.reply_byte = r_light;
                POS_BUTTONS: res.reply_byte = r_buttons;
                POS_ZERO:    res.reply_byte = 8'h00;
                POS_END:     res.reply_byte = END_MARK;
                default:     res.reply_byte = 8'h00;
            endcase
            n_pos = r_pos + POS_W'(1);
            if (r_in.spi_byte == END_MARK) begin
                res.frame_done = 1'b1;
                n_pos          = '0;
                // The end mark itself sits in the last slot, so a full
                // frame only needs its padding checked.
                if ((r_pos == POS_END) && pads_zero) begin
                    res.frame_valid = 1'b1;
                    unique case (opcode)
                        OP_TURN_ON:     n_override = r_override ^ (param & ~r_light);
                        OP_TURN_OFF:    n_override = r_override ^ (param & r_light);
                        OP_ALL:         n_override = (param == 8'h00) ?
                                                     (r_override ^ r_light) :
                                                     (r_override ^ ~r_light);
                        OP_BUTTONS_OFF: n_btn_off  = 1'b1;
                        OP_BUTTONS_ON:  n_btn_off  = 1'b0;
                        default:        n_override = r_override;
                    endcase
                end else begin
                    n_err_sticky = 1'b1;
                    n_err_recent = 1'b1;
                end
            end
        end else begin
            // Six bytes went by without an end mark: drop back to the start.
            n_pos = '0;
        end

        res.lights = n_light;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pos        <= '0;
            r_override   <= '0;
            r_buttons    <= '0;
            r_btn_off    <= 1'b0;
            r_sensors    <= '0;
            r_light      <= '0;
            r_err_sticky <= 1'b0;
            r_err_recent <= 1'b0;
        end else begin
            if (i_item.ready) begin
                r_in_valid <= i_item.valid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
            if (step) begin
                r_pos        <= n_pos;
                r_override   <= n_override;
                r_buttons    <= n_buttons;
                r_btn_off    <= n_btn_off;
                r_sensors    <= n_sensors;
                r_light      <= n_light;
                r_err_sticky <= n_err_sticky;
                r_err_recent <= n_err_recent;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.ready && i_item.valid) begin
            r_in <= i_item.payload;
        end
        if (step) begin
            r_out <= res;
        end
        if (store_wr) begin
            r_store[r_pos] <= r_in.spi_byte;
        end
    end

    `SLCS_ASSERT_SAME(a_valid_needs_done, i_clk, i_rst_n,
        r_out_valid && r_out.frame_valid, r_out.frame_done,
        "frame reported valid without ending a frame")

    `SLCS_ASSERT_NEXT(a_bad_frame_sets_error, i_clk, i_rst_n,
        step && res.frame_done && !res.frame_valid, r_err_sticky && r_err_recent,
        "malformed frame did not raise the error reply")

    `SLCS_ASSERT_NEXT(a_sample_clears_recent, i_clk, i_rst_n,
        step && (r_in.command == CMD_SAMPLE), !r_err_recent,
        "sample did not clear the recent error reply")

    `SLCS_ASSERT_NEXT(a_input_held_on_stall, i_clk, i_rst_n,
        r_in_valid && !advance, r_in_valid && $stable(r_in),
        "pending item lost while the result register was stalled")

endmodule

FILE: tb/sv/spi_light_command_slave_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// SPI light command slave: testbench
// Drives sample items and SPI bytes through the item channel and checks every
// result transfer against a cycle-free predictor of the light controller or a
// fixed row's typed result. A short hand-picked table comes first, then a long
// random stream of mostly well-formed frames, with random stalls on both sides.
// ----------------------------------------------------------------------------
module spi_light_command_slave_tb;
    import slcs_pkg::*;

    localparam int CLK_HALF          = 10;
    localparam int RESET_CYCLES      = 5;
    localparam int DIRECTED_ROWS     = 25;
    localparam int RANDOM_ITEMS      = 525;
    // Worst case is roughly 550 items, each behind the longest idle gap and the
    // longest stall, plus the long hold-off.
    localparam int CYCLE_LIMIT       = 200000;
    // Two register stages between input and result, plus some margin.
    localparam int DRAIN_CYCLES      = 8;
    localparam int LONG_STALL_AT     = 150;
    localparam int LONG_STALL_CYCLES = 80;
    localparam int REPORT_LIMIT      = 10;

    // One row of the directed table. Where fixed is set, the result is the
    // one typed into the row; otherwise the predictor supplies it.
    typedef struct packed {
        logic      fixed;
        t_in_item  item;
        t_out_item result;
    } t_stim_row;

    logic i_clk;
    logic i_rst_n;

    slcs_in_if  item_ch ();
    slcs_out_if result_ch ();

    spi_light_command_slave dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .o_result (result_ch)
    );

    // ------------------------------------------------------------------------
    // Directed table. The first rows run a clean turn-on frame straight after
    // reset, where every reply byte is obvious. Then buttons are locked, a
    // lone end mark makes a short frame and raises the error bytes, and six
    // bytes with no end mark are followed by a seventh, which overflows the
    // frame and must reply zero without ending anything.
    // ------------------------------------------------------------------------
    t_stim_row directed_rows [DIRECTED_ROWS] = '{
        // All buttons pressed, all sensors high: lights follow the buttons.
        '{1'b1, '{CMD_SAMPLE, 8'h00, 8'h00, 8'hFF}, '{8'h00, 8'hFF, 1'b0, 1'b0}},
        // All buttons released, all sensors low.
        '{1'b1, '{CMD_SAMPLE, 8'h00, 8'hFF, 8'h00}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        // Turn-on frame; the pin fields of SPI items are ignored by the block.
        '{1'b1, '{CMD_SPI, OP_TURN_ON, 8'hFF, 8'hFF}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{1'b1, '{CMD_SPI, 8'hA5, 8'h00, 8'h00}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{1'b1, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{1'b1, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{1'b1, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '{8'h00, 8'h00, 1'b0, 1'b0}},
        '{1'b1, '{CMD_SPI, END_MARK, 8'h00, 8'h00}, '{END_MARK, 8'h00, 1'b1, 1'b1}},
        // The new override shows only once the next sample is taken.
        '{1'b0, '{CMD_SAMPLE, 8'h00, 8'hFF, 8'h3C}, '0},
        // Lock the buttons.
        '{1'b0, '{CMD_SPI, OP_BUTTONS_OFF, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, END_MARK, 8'h00, 8'h00}, '0},
        // Every button pressed, but the latch must keep its old value.
        '{1'b0, '{CMD_SAMPLE, 8'h00, 8'h00, 8'h81}, '0},
        // A lone end mark is a short frame, so it fails the check.
        '{1'b0, '{CMD_SPI, END_MARK, 8'h00, 8'h00}, '0},
        // The first reply byte of the next frame carries the error mark.
        '{1'b1, '{CMD_SPI, 8'h42, 8'h00, 8'h00}, '{ERROR_MARK, 8'hA5, 1'b0, 1'b0}},
        // A sample clears the second error byte but not the first.
        '{1'b0, '{CMD_SAMPLE, 8'h00, 8'hAA, 8'h55}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h00, 8'h00, 8'h00}, '0},
        '{1'b0, '{CMD_SPI, 8'h7E, 8'h00, 8'h00}, '0},
        // Seventh byte of an unterminated frame: overflow, even on an end mark.
        '{1'b1, '{CMD_SPI, END_MARK, 8'h00, 8'h00}, '{8'h00, 8'hA5, 1'b0, 1'b0}}
    };

    // ------------------------------------------------------------------------
    // Predictor state: a behavioural copy of the controller's registers.
    // ------------------------------------------------------------------------
    logic [7:0]  lamp_override  = '0;
    logic [7:0]  held_buttons   = '0;
    logic [7:0]  held_sensors   = '0;
    logic [7:0]  lamp_levels    = '0;
    logic        buttons_locked = 1'b0;
    logic [7:0]  error_bytes [2] = '{default: '0};
    logic [7:0]  rx_frame [FRAME_BYTES] = '{default: '0};
    int unsigned rx_count = 0;

    // Results still owed by the block, oldest first.
    t_out_item   pending_results [$];
    t_in_item    stim_queue [$];
    // Frame position as the stream generator sees it, used only to start
    // generated frames on a frame boundary.
    int unsigned gen_count = 0;

    int unsigned fail_count    = 0;
    int unsigned results_taken = 0;
    int unsigned cycle_count   = 0;
    t_out_item   want_result;

    // Works out the result of one accepted item and advances the predictor.
    function automatic t_out_item light_ctrl_step(input t_in_item it);
        t_out_item  res;
        logic       frame_good;
        logic [7:0] arg;
        res = '0;
        if (it.command == CMD_SAMPLE) begin
            if (!buttons_locked) begin
                held_buttons = ~it.button_pins;
            end
            lamp_levels    = held_buttons ^ lamp_override;
            held_sensors   = it.sensor_pins;
            // The sample rewrites the sensor reply byte.
            error_bytes[1] = 8'h00;
        end else if (rx_count < FRAME_BYTES) begin
            case (rx_count)
                0: begin
                    res.reply_byte = error_bytes[0];
                end
                1: begin
                    res.reply_byte = (error_bytes[1] != 8'h00) ? error_bytes[1] : held_sensors;
                end
                2: begin
                    res.reply_byte = lamp_levels;
                end
                3: begin
                    res.reply_byte = held_buttons;
                end
                4: begin
                    res.reply_byte = 8'h00;
                end
                default: begin
                    res.reply_byte = END_MARK;
                end
            endcase
            rx_frame[rx_count] = it.spi_byte;
            rx_count++;
            if (it.spi_byte == END_MARK) begin
                res.frame_done = 1'b1;
                // A full count means this end mark sits in the last byte.
                frame_good = (rx_count == FRAME_BYTES) && (rx_frame[2] == 8'h00)
                    && (rx_frame[3] == 8'h00) && (rx_frame[4] == 8'h00);
                if (frame_good) begin
                    res.frame_valid = 1'b1;
                    arg = rx_frame[1];
                    // Lights are switched by flipping override bits wherever
                    // the present level differs from the one asked for.
                    case (rx_frame[0])
                        OP_TURN_ON: begin
                            lamp_override ^= arg & ~lamp_levels;
                        end
                        OP_TURN_OFF: begin
                            lamp_override ^= arg & lamp_levels;
                        end
                        OP_ALL: begin
                            lamp_override ^= (arg == 8'h00) ? lamp_levels : ~lamp_levels;
                        end
                        OP_BUTTONS_OFF: begin
                            buttons_locked = 1'b1;
                        end
                        OP_BUTTONS_ON: begin
                            buttons_locked = 1'b0;
                        end
                        default: begin
                            // Status, no-op and unknown codes change nothing.
                        end
                    endcase
                end else begin
                    error_bytes[0] = ERROR_MARK;
                    error_bytes[1] = ERROR_MARK;
                end
                rx_count = 0;
            end
        end else begin
            // Overflow: the byte is dropped and the frame starts afresh.
            rx_count = 0;
        end
        res.lights = lamp_levels;
        return res;
    endfunction

    // Idle lengths: mostly none or short, now and then a long one.
    function automatic int unsigned pick_idle();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 88) begin
            return $urandom_range(1, 3);
        end else if (r < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    task automatic queue_spi(input logic [7:0] value);
        t_in_item it;
        it.command     = CMD_SPI;
        it.spi_byte    = value;
        it.button_pins = 8'($urandom);
        it.sensor_pins = 8'($urandom);
        stim_queue.push_back(it);
        if (gen_count >= FRAME_BYTES || value == END_MARK) begin
            gen_count = 0;
        end else begin
            gen_count++;
        end
    endtask

    task automatic queue_sample();
        t_in_item it;
        it.command     = CMD_SAMPLE;
        it.spi_byte    = 8'($urandom);
        it.button_pins = 8'($urandom);
        it.sensor_pins = 8'($urandom);
        stim_queue.push_back(it);
    endtask

    // Queues one frame, realigning first if the stream is mid-frame. A
    // non-zero bad_value placed in one of the bytes 2 to 4 spoils the frame.
    task automatic queue_frame(input logic [7:0] opcode, input logic [7:0] arg,
                               input int unsigned bad_slot, input logic [7:0] bad_value);
        logic [7:0] value;
        if (gen_count != 0) begin
            queue_spi(END_MARK);
        end
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i == 0) begin
                value = opcode;
            end else if (i == 1) begin
                value = arg;
            end else if (i == FRAME_BYTES - 1) begin
                value = END_MARK;
            end else begin
                value = (i == bad_slot) ? bad_value : 8'h00;
            end
            // Samples may fall between the bytes of a frame.
            if ($urandom_range(0, 99) < 15) begin
                queue_sample();
            end
            queue_spi(value);
        end
    endtask

    // Offers one item after the given number of idle cycles and returns at
    // the rising edge at which it is accepted.
    task automatic send_item(input t_in_item it, input int unsigned gap);
        if (gap != 0) begin
            @(negedge i_clk);
            item_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        item_ch.valid   <= 1'b1;
        item_ch.payload <= it;
        @(posedge i_clk);
        while (!item_ch.ready) begin
            @(posedge i_clk);
        end
    endtask

    // Withdraws the sender and waits until every owed result has come back.
    task automatic drain_results();
        @(negedge i_clk);
        item_ch.valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------------
    // Clock.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever begin
            #(CLK_HALF) i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------------
    // Sender: reset, the directed table, then the random stream.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned burst_left;
        int unsigned sel;
        int unsigned pause_at;
        logic [7:0]  op;
        logic [7:0]  arg;
        t_out_item   predicted;

        burst_left      = 0;
        item_ch.valid   = 1'b0;
        item_ch.payload = '0;
        i_rst_n         = 1'b0;

        // The random stream is a mix of well-formed frames with random
        // content (most of it), lone samples, frames with a non-zero pad
        // byte, short frames, frames that run past six bytes, and loose bytes.
        while (stim_queue.size() < RANDOM_ITEMS) begin
            sel = $urandom_range(0, 99);
            if ($urandom_range(0, 6) == 0) begin
                op = 8'($urandom_range(OP_BUTTONS_ON + 1, 254));
            end else begin
                op = 8'($urandom_range(OP_STATUS, OP_BUTTONS_ON));
            end
            // A zero parameter matters to the all-lights command.
            arg = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom_range(0, 254));
            if (sel < 60) begin
                queue_frame(op, arg, 0, 8'h00);
            end else if (sel < 75) begin
                queue_sample();
            end else if (sel < 85) begin
                queue_frame(op, arg, $urandom_range(2, 4), 8'($urandom_range(1, 255)));
            end else if (sel < 92) begin
                repeat ($urandom_range(0, 4)) queue_spi(8'($urandom_range(0, 254)));
                queue_spi(END_MARK);
            end else if (sel < 97) begin
                if (gen_count != 0) begin
                    queue_spi(END_MARK);
                end
                repeat (FRAME_BYTES) queue_spi(8'($urandom_range(0, 254)));
                queue_spi(8'($urandom));
            end else begin
                queue_spi(8'($urandom));
            end
        end
        pause_at = stim_queue.size() / 2;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i]) begin
            send_item(directed_rows[i].item, pick_idle());
            predicted = light_ctrl_step(directed_rows[i].item);
            pending_results.push_back(directed_rows[i].fixed ? directed_rows[i].result
                                                             : predicted);
        end

        // The sender stops here until the block has handed back everything.
        drain_results();

        foreach (stim_queue[i]) begin
            if (i == pause_at) begin
                drain_results();
            end
            // Occasional bursts with no idle cycles at all.
            if (burst_left == 0 && $urandom_range(0, 49) == 0) begin
                burst_left = $urandom_range(20, 40);
            end
            if (burst_left != 0) begin
                burst_left--;
                send_item(stim_queue[i], 0);
            end else begin
                send_item(stim_queue[i], pick_idle());
            end
            pending_results.push_back(light_ctrl_step(stim_queue[i]));
        end

        drain_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random stalls, calm stretches with none, and one long
    // hold-off while the sender keeps offering, so that the block fills both
    // of its registers and lowers its input ready.
    // ------------------------------------------------------------------------
    initial begin
        int unsigned hold;
        int unsigned calm;
        logic        long_done;

        hold            = 0;
        calm            = 0;
        long_done       = 1'b0;
        result_ch.ready = 1'b0;
        while (!i_rst_n) begin
            @(negedge i_clk);
        end
        forever begin
            @(negedge i_clk);
            if (!long_done && results_taken >= LONG_STALL_AT) begin
                long_done = 1'b1;
                hold      = LONG_STALL_CYCLES;
            end else if (hold == 0 && calm == 0) begin
                if ($urandom_range(0, 99) < 4) begin
                    calm = $urandom_range(30, 60);
                end else if ($urandom_range(0, 2) == 0) begin
                    hold = pick_idle();
                end
            end
            if (hold != 0) begin
                result_ch.ready <= 1'b0;
                hold--;
            end else begin
                result_ch.ready <= 1'b1;
                if (calm != 0) begin
                    calm--;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every result transfer is matched, field by field,
    // against the oldest expectation.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            results_taken++;
            if (pending_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result transfer at cycle %0d: reply %02h lights %02h",
                             cycle_count, result_ch.payload.reply_byte,
                             result_ch.payload.lights);
                end
            end else begin
                want_result = pending_results.pop_front();
                if (result_ch.payload.reply_byte !== want_result.reply_byte
                        || result_ch.payload.lights !== want_result.lights
                        || result_ch.payload.frame_done !== want_result.frame_done
                        || result_ch.payload.frame_valid !== want_result.frame_valid) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display("mismatch on result %0d: reply %02h/%02h lights %02h/%02h",
                                 results_taken, result_ch.payload.reply_byte,
                                 want_result.reply_byte, result_ch.payload.lights,
                                 want_result.lights);
                        $display("    frame done %b/%b, frame valid %b/%b (got/expected)",
                                 result_ch.payload.frame_done, want_result.frame_done,
                                 result_ch.payload.frame_valid, want_result.frame_valid);
                    end
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

endmodule
